// ===== rtl/core/krt_pkg.sv =====
// ----------------------------------------------------------------------------
// krt_pkg
// Constants, codes and entry layout for the keyed record table.
// ----------------------------------------------------------------------------
package krt_pkg;

  localparam int TABLE_CAPACITY = 256;
  localparam int MAX_FILES      = 64;
  localparam int SLOT_W         = $clog2(TABLE_CAPACITY);
  localparam int CNT_W          = $clog2(TABLE_CAPACITY + 1);
  localparam int FILE_W         = 6;
  localparam int FCNT_W         = 7;
  localparam int KEY_W          = 64;
  localparam int ACT_W          = 3;
  localparam int STAT_W         = 3;
  localparam int LIVE_W         = 9;
  localparam int IN_DATA_W      = 72;
  localparam int OUT_DATA_W     = 24;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd2;
  localparam logic [ACT_W-1:0] ACT_LOCK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_UNLOCK = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd1;
  localparam logic [STAT_W-1:0] ST_LOCKED    = 3'd2;
  localparam logic [STAT_W-1:0] ST_DUP       = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_FILE  = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [FILE_W-1:0] file;
    logic              lock;
  } entry_t;

endpackage

// ===== rtl/core/keyed_record_table_with_locks.sv =====
// ----------------------------------------------------------------------------
// keyed_record_table_with_locks
// Associative table of 64-bit record keys with file number, lock bit and
// per-file live counts.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one action per item; m_* returns one result item per action.
//   cfg_* writes the file count in use; write it only while the block is idle.
//   Each item runs a full scan of the entry memory, one entry per cycle,
//   then a read of the per-file count memory and a write-back.
//   s_tready is low from acceptance until the write-back; the entry memory has
//   a single read port, so a new item is taken only once the last one is
//   through. The result sits in an output
//   register: a new item is taken while it waits, and a second result is held
//   back until m_tready takes the first.
//   Reset clears all entry valid bits, all file count valid bits, the entry count
//   and the file count register at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_record_table_with_locks (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // record_key, file_number, insert_locked, lock_override
  input  logic [krt_pkg::IN_DATA_W-1:0]  s_tdata,
  // action
  input  logic [krt_pkg::ACT_W-1:0]      s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // status, found, entry_locked, entry_file, enqueued, file_live_count, pad
  output logic [krt_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [krt_pkg::FCNT_W-1:0]     cfg_data
);
  import krt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_CNT, S_UPD} state_t;

  state_t                 state;
  entry_t                 ent_mem [TABLE_CAPACITY];
  logic [CNT_W-1:0]       cnt_mem [MAX_FILES];
  logic [TABLE_CAPACITY-1:0] ent_vld;
  logic [MAX_FILES-1:0]   cnt_vld;
  logic [FCNT_W-1:0]      file_cnt;
  logic [CNT_W-1:0]       in_use;

  logic [ACT_W-1:0]       act;
  logic [KEY_W-1:0]       key;
  logic [FILE_W-1:0]      fnum;
  logic                   ins_lock;
  logic                   ovr;

  logic [CNT_W-1:0]       idx;
  logic [SLOT_W-1:0]      rd_slot;
  logic                   rd_pend;
  entry_t                 rd_ent;
  logic                   hit;
  logic [SLOT_W-1:0]      hit_slot;
  entry_t                 hit_ent;
  logic                   have_free;
  logic [SLOT_W-1:0]      free_slot;
  logic [FILE_W-1:0]      tfile;
  logic [FILE_W-1:0]      tfile_sel;
  logic                   tfile_vld;
  logic [CNT_W-1:0]       cnt_rd;

  logic                   out_vld;
  logic [OUT_DATA_W-1:0]  out_data;

  logic [FCNT_W-1:0]      limit;
  logic                   bad_file;
  logic [CNT_W-1:0]       cnt_cur;
  logic [STAT_W-1:0]      r_status;
  logic                   r_lock;
  logic [FILE_W-1:0]      r_file;
  logic                   r_enq;
  logic [CNT_W-1:0]       r_cnt;
  logic                   r_zero;
  logic                   do_ins;
  logic                   do_rem;
  logic                   do_lck;
  logic                   upd_go;
  logic                   rd_hit;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign m_tvalid  = out_vld;
  assign m_tdata   = out_data;

  assign limit     = (file_cnt > FCNT_W'(MAX_FILES)) ? FCNT_W'(MAX_FILES) : file_cnt;
  assign bad_file  = ({1'b0, fnum} >= limit);
  assign cnt_cur   = tfile_vld ? cnt_rd : '0;
  assign upd_go    = (state == S_UPD) && (!out_vld || m_tready);
  assign rd_hit    = rd_pend && ent_vld[rd_slot] && (rd_ent.key == key);
  assign tfile_sel = (act == ACT_INSERT && !hit) ? fnum : hit_ent.file;

  always_comb begin
    r_status = ST_OK;
    r_zero   = 1'b0;
    r_lock   = hit_ent.lock;
    r_file   = hit_ent.file;
    r_cnt    = cnt_cur;
    do_ins   = 1'b0;
    do_rem   = 1'b0;
    do_lck   = 1'b0;
    case (act)
      ACT_INSERT: begin
        if (bad_file) begin
          r_status = ST_BAD_FILE;
          r_zero   = !hit;
        end else if (hit) begin
          r_status = ST_DUP;
        end else if (in_use >= CNT_W'(TABLE_CAPACITY) || !have_free) begin
          r_status = ST_FULL;
          r_zero   = 1'b1;
        end else begin
          do_ins = 1'b1;
          r_lock = ins_lock;
          r_file = fnum;
          r_cnt  = cnt_cur + 1'b1;
        end
      end
      ACT_REMOVE: begin
        if (!hit) begin
          r_status = ST_NOT_FOUND;
          r_zero   = 1'b1;
        end else if (hit_ent.lock && !ovr) begin
          r_status = ST_LOCKED;
        end else begin
          do_rem = 1'b1;
          r_lock = 1'b0;
          r_cnt  = (cnt_cur != '0) ? cnt_cur - 1'b1 : '0;
        end
      end
      ACT_LOCK, ACT_UNLOCK: begin
        if (!hit) begin
          r_status = ST_NOT_FOUND;
          r_zero   = 1'b1;
        end else begin
          do_lck = 1'b1;
          r_lock = (act == ACT_LOCK);
        end
      end
      default: begin
        if (!hit) begin
          r_status = ST_NOT_FOUND;
          r_zero   = 1'b1;
        end else if (hit_ent.lock) begin
          r_status = ST_LOCKED;
        end
      end
    endcase
    r_enq = (!r_lock || ovr) && !do_rem;
    if (r_zero) begin
      r_lock = 1'b0;
      r_file = '0;
      r_enq  = 1'b0;
      r_cnt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SCAN && idx < CNT_W'(TABLE_CAPACITY)) begin
      rd_ent <= ent_mem[idx[SLOT_W-1:0]];
    end
    if (state == S_CNT) begin
      cnt_rd <= cnt_mem[tfile_sel];
    end
    if (upd_go && do_ins) begin
      ent_mem[free_slot] <= '{key: key, file: fnum, lock: ins_lock};
    end
    if (upd_go && do_lck) begin
      ent_mem[hit_slot] <= '{key: hit_ent.key, file: hit_ent.file, lock: r_lock};
    end
    if (upd_go && (do_ins || do_rem)) begin
      cnt_mem[tfile] <= r_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ent_vld  <= '0;
      cnt_vld  <= '0;
      file_cnt <= '0;
      in_use   <= '0;
      out_vld  <= 1'b0;
      rd_pend  <= 1'b0;
      idx      <= '0;
    end else begin
      if (cfg_valid) begin
        file_cnt <= cfg_data;
      end
      if (out_vld && m_tready && !upd_go) begin
        out_vld <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act       <= s_tuser;
            key       <= s_tdata[KEY_W-1:0];
            fnum      <= s_tdata[KEY_W+FILE_W-1:KEY_W];
            ins_lock  <= s_tdata[KEY_W+FILE_W];
            ovr       <= s_tdata[KEY_W+FILE_W+1];
            idx       <= '0;
            rd_pend   <= 1'b0;
            hit       <= 1'b0;
            have_free <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= (idx < CNT_W'(TABLE_CAPACITY));
          rd_slot <= idx[SLOT_W-1:0];
          if (idx < CNT_W'(TABLE_CAPACITY)) begin
            idx <= idx + 1'b1;
          end
          if (rd_hit && !hit) begin
            hit      <= 1'b1;
            hit_slot <= rd_slot;
            hit_ent  <= rd_ent;
          end
          if (rd_pend && !ent_vld[rd_slot] && !have_free) begin
            have_free <= 1'b1;
            free_slot <= rd_slot;
          end
          if (rd_pend && rd_slot == SLOT_W'(TABLE_CAPACITY - 1)) begin
            state <= S_CNT;
          end
        end
        S_CNT: begin
          tfile     <= tfile_sel;
          tfile_vld <= cnt_vld[tfile_sel];
          state     <= S_UPD;
        end
        S_UPD: begin
          if (upd_go) begin
            if (do_ins) begin
              ent_vld[free_slot] <= 1'b1;
              in_use             <= in_use + 1'b1;
            end
            if (do_rem) begin
              ent_vld[hit_slot] <= 1'b0;
              in_use            <= (in_use != '0) ? in_use - 1'b1 : '0;
            end
            if (do_ins || do_rem) begin
              cnt_vld[tfile] <= 1'b1;
            end
            out_vld  <= 1'b1;
            out_data <= {3'b000, LIVE_W'(r_cnt), r_enq, r_file, r_lock, hit, r_status};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count memory address in S_CNT comes from the scan result, or from the item's file number for a new insert
  a_in_use_max: assert property (@(posedge clk) disable iff (rst)
    in_use <= CNT_W'(TABLE_CAPACITY))
    else $error("entry count above capacity");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !rd_pend || state == S_IDLE)
    else $error("input taken while a scan read is pending");

  a_upd_emits: assert property (@(posedge clk) disable iff (rst)
    upd_go |=> out_vld && state == S_IDLE)
    else $error("update did not produce a result");

  a_ins_free: assert property (@(posedge clk) disable iff (rst)
    (upd_go && do_ins) |-> !ent_vld[free_slot])
    else $error("insert into an occupied slot");

endmodule
